// ===== hdl/bfpca_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpca_pkg
// Field widths, command codes and status codes shared by the best-fit page
// chunk allocator and its channel interfaces.
// ----------------------------------------------------------------------------
package bfpca_pkg;

  localparam int PAGE_IDX_W = 8;
  localparam int OFFSET_W   = 12;
  localparam int SIZE_W     = 13;
  localparam int AGE_W      = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [SIZE_W-1:0] MIN_SPLIT_RESET = SIZE_W'(16);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_NO_PAGE    = 2'd2,
    ST_BAD_SIZE   = 2'd3
  } status_t;

endpackage

// ===== hdl/bfpca_req_if.sv =====
// ----------------------------------------------------------------------------
// bfpca_req_if
// Request channel: allocate or free command with the chunk fields.
// ----------------------------------------------------------------------------
interface bfpca_req_if;
  import bfpca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [PAGE_IDX_W-1:0] chunk_page;
  logic [OFFSET_W-1:0]   chunk_offset;
  logic [SIZE_W-1:0]     chunk_size;

  modport source (output valid, cmd, chunk_page, chunk_offset, chunk_size, input ready);
  modport sink   (input valid, cmd, chunk_page, chunk_offset, chunk_size, output ready);
endinterface

// ===== hdl/bfpca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfpca_rsp_if
// Response channel: status and the granted chunk.
// ----------------------------------------------------------------------------
interface bfpca_rsp_if;
  import bfpca_pkg::*;

  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [PAGE_IDX_W-1:0] grant_page;
  logic [OFFSET_W-1:0]   grant_offset;
  logic [SIZE_W-1:0]     grant_size;

  modport source (output valid, status, grant_page, grant_offset, grant_size, input ready);
  modport sink   (input valid, status, grant_page, grant_offset, grant_size, output ready);
endinterface

// ===== hdl/bfpca_ram.sv =====
// ----------------------------------------------------------------------------
// bfpca_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfpca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/best_fit_page_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_chunk_allocator
// Best-fit allocator over a table of free chunks kept in one entry RAM.
// Each request is checked as it is taken, then the entry RAM is scanned
// through its single read port, and the response is registered in the
// decide step; a request with a bad size skips the scan. One item at a time:
// no new request is taken until the last one has been decided. After reset
// the entry RAM is cleared entry by entry before the first item is taken.
// ----------------------------------------------------------------------------
module best_fit_page_chunk_allocator #(
  parameter int PAGE_BYTES   = 4096,
  parameter int FREE_ENTRIES = 64,
  parameter int MAX_PAGES    = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bfpca_pkg::SIZE_W-1:0] cfg_wr_data,
  bfpca_req_if.sink                    req,
  bfpca_rsp_if.source                  rsp
);
  import bfpca_pkg::*;

  localparam int ENT_OFF_W = $clog2(PAGE_BYTES);
  localparam int ENT_LEN_W = $clog2(PAGE_BYTES + 1);
  localparam int CW        = ((ENT_LEN_W > SIZE_W) ? ENT_LEN_W : SIZE_W) + 1;
  localparam int AW        = $clog2(FREE_ENTRIES);
  localparam int CNT_W     = $clog2(FREE_ENTRIES + 1);
  localparam int PO_W      = $clog2(MAX_PAGES + 1);
  localparam int EW        = 1 + PAGE_IDX_W + ENT_OFF_W + ENT_LEN_W + AGE_W;

  localparam logic [CW-1:0]    PAGE_C  = CW'(PAGE_BYTES);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(FREE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LST = CNT_W'(FREE_ENTRIES - 1);
  localparam logic [PO_W-1:0]  PO_MAX  = PO_W'(MAX_PAGES);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]      cnt;
  logic                  rd_pend;
  logic [AW-1:0]         rd_idx;
  logic [SIZE_W-1:0]     min_split;
  logic [AGE_W-1:0]      insert_counter;
  logic [PO_W-1:0]       pages_opened;

  logic                  req_cmd;
  logic [PAGE_IDX_W-1:0] req_page;
  logic [OFFSET_W-1:0]   req_off;
  logic [SIZE_W-1:0]     req_size;
  logic                  req_bad;
  logic [CW-1:0]         req_grant;

  logic                  slot_found;
  logic [AW-1:0]         slot_idx;
  logic                  found;
  logic [AW-1:0]         best_idx;
  logic [ENT_LEN_W-1:0]  best_len;
  logic [AGE_W-1:0]      best_dist;
  logic [PAGE_IDX_W-1:0] best_page;
  logic [ENT_OFF_W-1:0]  best_off;

  logic                  out_valid;
  status_t               out_status;
  logic [PAGE_IDX_W-1:0] out_page;
  logic [OFFSET_W-1:0]   out_off;
  logic [SIZE_W-1:0]     out_size;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;

  bfpca_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Entry word layout: valid, page, offset, length, age.
  logic                  ent_valid;
  logic [PAGE_IDX_W-1:0] ent_page;
  logic [ENT_OFF_W-1:0]  ent_off;
  logic [ENT_LEN_W-1:0]  ent_len;
  logic [AGE_W-1:0]      ent_age;
  logic [AGE_W-1:0]      ent_dist;
  logic                  ent_fits;
  logic                  ent_better;

  assign ent_valid = ram_rdata[EW-1];
  assign ent_page  = ram_rdata[EW-2 -: PAGE_IDX_W];
  assign ent_off   = ram_rdata[AGE_W+ENT_LEN_W +: ENT_OFF_W];
  assign ent_len   = ram_rdata[AGE_W +: ENT_LEN_W];
  assign ent_age   = ram_rdata[AGE_W-1:0];

  // Older entries sit farther back from the insert counter, which may wrap.
  assign ent_dist   = insert_counter - ent_age;
  assign ent_fits   = ent_valid && (CW'(ent_len) >= CW'(req_size));
  assign ent_better = !found || (ent_len < best_len) ||
                      ((ent_len == best_len) && (ent_dist > best_dist));

  // Checks and the new-page grant are worked out as the item is taken.
  logic [CW-1:0] split_w;
  logic [CW-1:0] in_size_w;
  logic [CW-1:0] in_end;
  logic          in_bad;
  logic [CW-1:0] in_grant_raw;
  logic [CW-1:0] in_grant;

  assign split_w      = (min_split == '0) ? CW'(1) : CW'(min_split);
  assign in_size_w    = CW'(req.chunk_size);
  assign in_end       = CW'(req.chunk_offset) + in_size_w;
  assign in_bad       = (req.chunk_size == '0) || (in_size_w > PAGE_C) ||
                        ((req.cmd == CMD_FREE) && (in_end > PAGE_C));
  assign in_grant_raw = (in_size_w >= split_w) ? in_size_w : split_w;
  assign in_grant     = (in_grant_raw > PAGE_C) ? PAGE_C : in_grant_raw;

  // Outcome of the item once the scan is done.
  logic [CW-1:0]         left;
  logic                  keep_rest;
  logic [CW-1:0]         split_off;
  logic [CW-1:0]         new_rest;
  status_t               dec_status;
  logic [PAGE_IDX_W-1:0] dec_page;
  logic [OFFSET_W-1:0]   dec_off;
  logic [SIZE_W-1:0]     dec_size;
  logic                  dec_we;
  logic [AW-1:0]         dec_waddr;
  logic [EW-1:0]         dec_wdata;
  logic                  dec_bump;
  logic                  dec_open;
  logic                  dec_fire;

  assign left      = CW'(best_len) - CW'(req_size);
  assign keep_rest = left >= split_w;
  assign split_off = CW'(best_off) + CW'(req_size);
  assign new_rest  = PAGE_C - req_grant;
  assign dec_fire  = (state == S_DECIDE) && (!out_valid || rsp.ready);

  always_comb begin
    dec_status = ST_OK;
    dec_page   = '0;
    dec_off    = '0;
    dec_size   = '0;
    dec_we     = 1'b0;
    dec_waddr  = slot_idx;
    dec_wdata  = '0;
    dec_bump   = 1'b0;
    dec_open   = 1'b0;
    if (req_bad) begin
      dec_status = ST_BAD_SIZE;
    end else if (req_cmd == CMD_FREE) begin
      if (!slot_found) begin
        dec_status = ST_TABLE_FULL;
      end else begin
        dec_we    = 1'b1;
        dec_wdata = {1'b1, req_page, ENT_OFF_W'(req_off), ENT_LEN_W'(req_size),
                     insert_counter};
        dec_bump  = 1'b1;
      end
    end else if (found) begin
      dec_page  = best_page;
      dec_off   = OFFSET_W'(best_off);
      dec_we    = 1'b1;
      dec_waddr = best_idx;
      if (keep_rest) begin
        dec_size  = req_size;
        dec_wdata = {1'b1, best_page, ENT_OFF_W'(split_off), ENT_LEN_W'(left),
                     insert_counter};
        dec_bump  = 1'b1;
      end else begin
        // The whole chunk goes out and its entry is dropped.
        dec_size  = SIZE_W'(best_len);
      end
    end else if (pages_opened >= PO_MAX) begin
      dec_status = ST_NO_PAGE;
    end else if ((new_rest != '0) && !slot_found) begin
      dec_status = ST_TABLE_FULL;
    end else begin
      dec_open = 1'b1;
      dec_page = PAGE_IDX_W'(pages_opened);
      dec_size = SIZE_W'(req_grant);
      if (new_rest != '0) begin
        dec_we    = 1'b1;
        dec_wdata = {1'b1, PAGE_IDX_W'(pages_opened), ENT_OFF_W'(req_grant),
                     ENT_LEN_W'(new_rest), insert_counter};
        dec_bump  = 1'b1;
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = dec_fire && dec_we;
      ram_waddr = dec_waddr;
      ram_wdata = dec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      cnt            <= '0;
      rd_pend        <= 1'b0;
      out_valid      <= 1'b0;
      min_split      <= MIN_SPLIT_RESET;
      insert_counter <= '0;
      pages_opened   <= '0;
    end else begin
      if (cfg_wr_en) begin
        min_split <= cfg_wr_data;
      end
      // A new result taken on the same edge keeps the output valid.
      if (rsp.valid && rsp.ready && !dec_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            req_cmd    <= req.cmd;
            req_page   <= req.chunk_page;
            req_off    <= req.chunk_offset;
            req_size   <= req.chunk_size;
            req_bad    <= in_bad;
            req_grant  <= in_grant;
            cnt        <= '0;
            rd_pend    <= 1'b0;
            found      <= 1'b0;
            slot_found <= 1'b0;
            state      <= in_bad ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued one entry a cycle; the registered read data returns in the next cycle.
          if (cnt != CNT_END) begin
            cnt <= cnt + CNT_W'(1);
          end
          rd_pend <= (cnt != CNT_END);
          rd_idx  <= cnt[AW-1:0];
          if (rd_pend) begin
            if (!ent_valid && !slot_found) begin
              slot_found <= 1'b1;
              slot_idx   <= rd_idx;
            end
            if (ent_fits && ent_better) begin
              found     <= 1'b1;
              best_idx  <= rd_idx;
              best_len  <= ent_len;
              best_dist <= ent_dist;
              best_page <= ent_page;
              best_off  <= ent_off;
            end
          end
          if ((cnt == CNT_END) && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_fire) begin
            out_valid  <= 1'b1;
            out_status <= dec_status;
            out_page   <= dec_page;
            out_off    <= dec_off;
            out_size   <= dec_size;
            if (dec_bump) begin
              insert_counter <= insert_counter + AGE_W'(1);
            end
            if (dec_open) begin
              pages_opened <= pages_opened + PO_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          cnt   <= '0;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.grant_page   = out_page;
  assign rsp.grant_offset = out_off;
  assign rsp.grant_size   = out_size;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an item was still in progress");

  a_error_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> (rsp.grant_size == '0) &&
    (rsp.grant_page == '0) && (rsp.grant_offset == '0))
    else $error("error response carries a grant");

  a_pages_bounded: assert property (@(posedge clk) disable iff (rst)
    pages_opened <= PO_MAX)
    else $error("page count ran past the page limit");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("response raised outside the decide step");

endmodule

// ===== bench/bfpca_grant_checker.sv =====
// ----------------------------------------------------------------------------
// bfpca_grant_checker
// Watches the request, response and configuration ports of the best-fit page
// chunk allocator. It keeps its own copy of the free-chunk table, predicts
// the grant for every accepted request and compares each accepted response
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bfpca_grant_checker #(
  parameter int PAGE_BYTES   = 4096,
  parameter int FREE_ENTRIES = 64,
  parameter int MAX_PAGES    = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [bfpca_pkg::SIZE_W-1:0] cfg_wr_data,
  bfpca_req_if                         req,
  bfpca_rsp_if                         rsp,
  output int                           mismatch_count,
  output int                           pending_results
);
  import bfpca_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [PAGE_IDX_W-1:0] page;
    logic [OFFSET_W-1:0]   offset;
    logic [SIZE_W-1:0]     size;
  } grant_t;

  logic [SIZE_W-1:0]     min_split;
  logic                  free_valid  [FREE_ENTRIES];
  logic [PAGE_IDX_W-1:0] free_page   [FREE_ENTRIES];
  logic [OFFSET_W-1:0]   free_offset [FREE_ENTRIES];
  logic [SIZE_W-1:0]     free_len    [FREE_ENTRIES];
  logic [AGE_W-1:0]      free_age    [FREE_ENTRIES];
  logic [AGE_W-1:0]      next_age;
  int                    page_count;
  grant_t                grant_q [$];

  function automatic int open_slot();
    for (int i = 0; i < FREE_ENTRIES; i++)
      if (!free_valid[i]) return i;
    return -1;
  endfunction

  function automatic void store_chunk(int slot, logic [PAGE_IDX_W-1:0] page,
                                      logic [OFFSET_W-1:0] offset, logic [SIZE_W-1:0] len);
    free_valid[slot]  = 1'b1;
    free_page[slot]   = page;
    free_offset[slot] = offset;
    free_len[slot]    = len;
    free_age[slot]    = next_age;
    next_age          = next_age + 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [PAGE_IDX_W-1:0] page,
                                           logic [OFFSET_W-1:0] offset,
                                           logic [SIZE_W-1:0] size);
    grant_t g;
    int     split;
    int     best;
    int     slot;
    int     leftover;
    int     grant;
    int     rest;
    g = '0;
    g.status = ST_OK;
    split = (min_split == '0) ? 1 : int'(min_split);
    if (size == '0 || int'(size) > PAGE_BYTES) begin
      g.status = ST_BAD_SIZE;
      return g;
    end

    if (cmd == CMD_FREE) begin
      if (int'(offset) + int'(size) > PAGE_BYTES) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      slot = open_slot();
      if (slot < 0) begin
        g.status = ST_TABLE_FULL;
        return g;
      end
      store_chunk(slot, page, offset, size);
      return g;
    end

    // Smallest chunk that fits; on equal lengths the oldest insertion wins,
    // where age is the distance back from the wrapping insert counter.
    best = -1;
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      if (!free_valid[i] || free_len[i] < size) continue;
      if (best < 0 || free_len[i] < free_len[best])
        best = i;
      else if (free_len[i] == free_len[best] &&
               AGE_W'(next_age - free_age[i]) > AGE_W'(next_age - free_age[best]))
        best = i;
    end

    if (best >= 0) begin
      g.page   = free_page[best];
      g.offset = free_offset[best];
      leftover = int'(free_len[best]) - int'(size);
      if (leftover < split) begin
        free_valid[best] = 1'b0;
        g.size = free_len[best];
      end else begin
        store_chunk(best, free_page[best], OFFSET_W'(int'(free_offset[best]) + int'(size)),
                    SIZE_W'(leftover));
        g.size = size;
      end
      return g;
    end

    if (page_count >= MAX_PAGES) begin
      g.status = ST_NO_PAGE;
      return g;
    end
    grant = (int'(size) >= split) ? int'(size) : split;
    if (grant > PAGE_BYTES) grant = PAGE_BYTES;
    rest = PAGE_BYTES - grant;
    slot = -1;
    if (rest != 0) begin
      slot = open_slot();
      if (slot < 0) begin
        g.status = ST_TABLE_FULL;
        return g;
      end
    end
    g.page = PAGE_IDX_W'(page_count);
    g.size = SIZE_W'(grant);
    if (rest != 0) store_chunk(slot, PAGE_IDX_W'(page_count), OFFSET_W'(grant), SIZE_W'(rest));
    page_count++;
    return g;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      for (int i = 0; i < FREE_ENTRIES; i++) free_valid[i] = 1'b0;
      next_age   = '0;
      page_count = 0;
      min_split  = MIN_SPLIT_RESET;
      grant_q.delete();
      pending_results <= 0;
    end else begin
      if (cfg_wr_en) min_split = cfg_wr_data;
      // Predict before comparing so that a request and a response accepted on
      // the same edge are handled in order.
      if (req.valid && req.ready)
        grant_q.push_back(predict_grant(req.cmd, req.chunk_page, req.chunk_offset,
                                        req.chunk_size));
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          $error("response with no request outstanding: status %0d page %0d",
                 rsp.status, rsp.grant_page);
          mismatch_count++;
        end else begin
          want = grant_q.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("grant_page", want.page, rsp.grant_page);
          check_field("grant_offset", want.offset, rsp.grant_offset);
          check_field("grant_size", want.size, rsp.grant_size);
        end
      end
      pending_results <= grant_q.size();
    end
  end

endmodule

// ===== bench/best_fit_page_chunk_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// best_fit_page_chunk_allocator_tb
// Drives allocate and free requests into the allocator with random gaps and
// random response stalls, changes min_split between phases, and reports the
// verdict from the grant checker that runs beside the block.
// ----------------------------------------------------------------------------
module best_fit_page_chunk_allocator_tb;
  import bfpca_pkg::*;

  localparam int PAGE_BYTES     = 4096;
  localparam int FREE_ENTRIES   = 64;
  localparam int MAX_PAGES      = 256;
  localparam int WATCHDOG_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  int                mismatch_count;
  int                pending_results;
  int                quiet_cycles = 0;
  int                req_gap_max = 10;
  int                rsp_gap_max = 10;

  bfpca_req_if req_ch ();
  bfpca_rsp_if rsp_ch ();

  best_fit_page_chunk_allocator #(
    .PAGE_BYTES  (PAGE_BYTES),
    .FREE_ENTRIES(FREE_ENTRIES),
    .MAX_PAGES   (MAX_PAGES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  bfpca_grant_checker #(
    .PAGE_BYTES  (PAGE_BYTES),
    .FREE_ENTRIES(FREE_ENTRIES),
    .MAX_PAGES   (MAX_PAGES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: a random stall before each item, then ready until taken.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(rsp_gap_max);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  task automatic send_item(logic cmd, int page, int offset, int size);
    int gap;
    gap = $urandom_range(req_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.chunk_page   <= PAGE_IDX_W'(page);
    req_ch.chunk_offset <= OFFSET_W'(offset);
    req_ch.chunk_size   <= SIZE_W'(size);
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_alloc(int size);
    send_item(CMD_ALLOC, $urandom_range(255), $urandom_range(4095), size);
  endtask

  // A free that always lies inside its page.
  task automatic send_random_free(int max_len);
    int offset;
    int len;
    offset = $urandom_range(PAGE_BYTES - 1);
    len = $urandom_range(max_len, 1);
    if (offset + len > PAGE_BYTES) len = PAGE_BYTES - offset;
    send_item(CMD_FREE, $urandom_range(255), offset, len);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_min_split(int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= SIZE_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Fill the table with tiny chunks, overflow it, then ask for a size that
  // nothing fits so a new page has nowhere to park its remainder.
  task automatic fill_free_table();
    repeat (70) send_random_free(8);
    send_alloc(PAGE_BYTES - 1);
  endtask

  task automatic random_request();
    int pick;
    int tier;
    int offset;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_item($urandom_range(1) ? CMD_FREE : CMD_ALLOC, $urandom_range(255),
                $urandom_range(4095), $urandom_range(1) ? 0 : $urandom_range(8191, 4097));
    end else if (pick < 7) begin
      // Free running past the end of its page.
      offset = $urandom_range(PAGE_BYTES - 1, 1);
      send_item(CMD_FREE, $urandom_range(255), offset,
                $urandom_range(PAGE_BYTES, PAGE_BYTES + 1 - offset));
    end else if (pick < 55) begin
      tier = $urandom_range(9);
      if (tier < 7) send_alloc($urandom_range(256, 1));
      else if (tier < 9) send_alloc($urandom_range(2048, 257));
      else send_alloc($urandom_range(PAGE_BYTES, 2049));
    end else begin
      send_random_free(($urandom_range(4) == 0) ? PAGE_BYTES : 512);
    end
  endtask

  task automatic run_phase(int split, int count, int req_gap, int rsp_gap);
    int sent;
    int pick;
    int burst;
    write_min_split(split);
    req_gap_max = req_gap;
    rsp_gap_max = rsp_gap;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        fill_free_table();
        sent += 71;
      end else if (pick < 8) begin
        burst = $urandom_range(16, 4);
        repeat (burst) send_random_free(64);
        sent += burst;
      end else begin
        random_request();
        sent++;
      end
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_ALLOC;
    req_ch.chunk_page   <= '0;
    req_ch.chunk_offset <= '0;
    req_ch.chunk_size   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Bad sizes on both commands, and a free that overruns its page.
    send_alloc(0);
    send_alloc(PAGE_BYTES + 1);
    send_alloc(8191);
    send_item(CMD_FREE, 0, 0, 0);
    send_item(CMD_FREE, 0, 4095, 2);
    // Page index is not checked against the opened pages.
    send_item(CMD_FREE, 255, 4095, 1);
    send_alloc(1);
    send_alloc(1);
    send_alloc(PAGE_BYTES);
    // Two chunks of equal length: the older one must win.
    send_item(CMD_FREE, 7, 100, 50);
    send_item(CMD_FREE, 8, 200, 50);
    send_alloc(40);
    send_alloc(20);
    send_alloc(4080);
    send_item(CMD_FREE, 0, 0, PAGE_BYTES);
    send_alloc(PAGE_BYTES);
    // A zero min_split acts as one.
    write_min_split(0);
    send_alloc(29);
    send_alloc(1);
    // min_split above a page caps the new-page grant.
    write_min_split(8191);
    send_alloc(5);

    write_min_split(MIN_SPLIT_RESET);
    fill_free_table();
    run_phase(16, 330, 10, 10);
    run_phase(1, 250, 0, 0);
    run_phase(0, 200, 3, 10);
    run_phase(8191, 150, 10, 10);
    // Full-page requests until the page supply runs out.
    repeat (320) send_alloc(PAGE_BYTES);
    run_phase(PAGE_BYTES, 250, 10, 10);
    run_phase($urandom_range(PAGE_BYTES - 1, 2), 200, 0, 10);

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
